>>> design/cpa_pkg.sv
// Shared types and constants for the column partition allocator.
package cpa_pkg;

  localparam int MAX_COLS_D     = 32;
  localparam int MAX_PARTS_D    = 16;
  localparam int MAX_REQUESTS_D = 16;
  localparam int MAX_CANDS_D    = 16;
  localparam int MAX_LAYOUTS_D  = 8;

  localparam logic [1:0] FN_CAND    = 2'd0;
  localparam logic [1:0] FN_ALLOC   = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_UNUSED  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_BAD      = 3'd5;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_SHARE = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] request_id;
    logic [2:0]  cand_layout;
    logic [3:0]  cand_option;
    logic [5:0]  cand_width;
    logic [4:0]  cand_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] chosen_layout;
    logic [3:0] chosen_option;
    logic [4:0] granted_start;
    logic [5:0] granted_width;
    logic       load_needed;
  } out_word_t;

  typedef struct packed {
    logic [2:0] layout;
    logic [3:0] option;
    logic [5:0] width;
    logic [4:0] start;
  } cand_t;

  // Command passed from front to back end.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] request_id;
    logic [4:0]  ncand;
  } cmd_t;

endpackage

>>> design/cpa_front.sv
// Front end: takes commands, stores candidates, queues allocate and release.
module cpa_front import cpa_pkg::*; #(
  parameter int MAX_CANDS = MAX_CANDS_D
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_word_t in_word,
  output cmd_t     q_cmd,
  output logic     q_valid,
  input  logic     q_pop,
  input  logic [$clog2(MAX_CANDS)-1:0] cand_raddr,
  output cand_t    cand_rdata
);
  localparam int CW = $clog2(MAX_CANDS + 1);
  localparam int AW = $clog2(MAX_CANDS);

  cand_t          cand_mem [MAX_CANDS];
  logic [CW-1:0]  cnt_r;
  cmd_t           q_r;
  logic           qv_r;
  logic           acc;

  // one-deep queue; the candidate list is owned by the back end until popped
  assign busy    = qv_r;
  assign acc     = start && !busy;
  assign q_cmd   = q_r;
  assign q_valid = qv_r;

  always_ff @(posedge clk) begin
    if (acc && in_word.func == FN_CAND && cnt_r < CW'(MAX_CANDS))
      cand_mem[cnt_r[AW-1:0]] <= '{in_word.cand_layout, in_word.cand_option,
                                   in_word.cand_width, in_word.cand_start};
    cand_rdata <= cand_mem[cand_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        qv_r <= 1'b0;
        if (q_r.func == FN_ALLOC) cnt_r <= '0;
      end
      if (acc) begin
        unique case (in_word.func)
          FN_CAND: if (cnt_r < CW'(MAX_CANDS)) cnt_r <= cnt_r + 1'b1;
          FN_ALLOC, FN_RELEASE: begin
            qv_r <= 1'b1;
            q_r  <= '{in_word.func, in_word.request_id, 5'(cnt_r)};
          end
          default: ;
        endcase
      end
    end
  end
endmodule

>>> design/cpa_back.sv
// Back end: sequential allocate and release engine over the tables.
module cpa_back import cpa_pkg::*; #(
  parameter int MAX_PARTS    = MAX_PARTS_D,
  parameter int MAX_REQUESTS = MAX_REQUESTS_D,
  parameter int MAX_CANDS    = MAX_CANDS_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [5:0] total_columns,
  input  logic      share_mode,
  input  cmd_t      q_cmd,
  input  logic      q_valid,
  output logic      q_pop,
  output logic [$clog2(MAX_CANDS)-1:0] cand_raddr,
  input  cand_t     cand_rdata,
  output logic      out_strobe,
  output out_word_t out_word
);
  localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int RW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int AW = $clog2(MAX_CANDS);
  localparam int CW = $clog2(MAX_CANDS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RSCAN, S_CREQ, S_CWAIT, S_CCHK, S_SREQ, S_SWAIT, S_SPART,
    S_PICK, S_PSLOT, S_COMMIT, S_REL
  } st_t;

  st_t st_r;
  logic [MAX_PARTS-1:0]    pv_r;
  logic [4:0]              pfc_r [MAX_PARTS];
  logic [5:0]              pcc_r [MAX_PARTS];
  logic [4:0]              psc_r [MAX_PARTS];
  logic [MAX_REQUESTS-1:0] rv_r;
  logic [31:0]             rid_r [MAX_REQUESTS];
  logic [PW-1:0]           rps_r [MAX_REQUESTS];
  logic [31:0] busy_r;
  logic [5:0]  inuse_r;
  logic [RW:0] ri_r;
  logic [PW:0] pi_r;
  logic [CW-1:0] ci_r;
  logic        found_r, part_ok_r, have_r;
  logic [RW-1:0] hit_r, rs_r;
  logic [PW-1:0] part_r;
  cand_t       sel_r;

  logic [5:0]  lim, freecols;
  logic [63:0] ones, winmask;
  logic        winfree;

  assign lim      = (total_columns > 6'(MAX_COLS_D)) ? 6'(MAX_COLS_D) : total_columns;
  assign freecols = (lim > inuse_r) ? lim - inuse_r : 6'd0;
  assign ones     = (64'd1 << cand_rdata.width) - 64'd1;
  assign winmask  = ones << cand_rdata.start;
  // busy bits beyond the limit count as busy
  assign winfree  = ((winmask & ~((64'd1 << lim) - 64'd1)) == 64'd0) &&
                    ((winmask[31:0] & busy_r) == 32'd0);
  assign cand_raddr = ci_r[AW-1:0];
  assign q_pop = (st_r == S_COMMIT) || (st_r == S_REL) ||
                 (st_r == S_PICK && !have_r) ||
                 (st_r == S_RSCAN && ri_r == (RW+1)'(MAX_REQUESTS) && found_r &&
                  q_cmd.func == FN_ALLOC) ||
                 (st_r == S_RSCAN && ri_r == (RW+1)'(MAX_REQUESTS) &&
                  q_cmd.func == FN_RELEASE && !found_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pv_r <= '0; rv_r <= '0; busy_r <= '0; inuse_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          st_r <= S_RSCAN; ri_r <= '0; found_r <= 1'b0; have_r <= 1'b0;
          part_ok_r <= 1'b0;
        end
        S_RSCAN: begin
          if (ri_r < (RW+1)'(MAX_REQUESTS)) begin
            if (rv_r[ri_r[RW-1:0]] && rid_r[ri_r[RW-1:0]] == q_cmd.request_id &&
                !found_r) begin
              found_r <= 1'b1; hit_r <= ri_r[RW-1:0];
            end
            ri_r <= ri_r + 1'b1;
          end else if (q_cmd.func == FN_ALLOC) begin
            if (found_r) begin
              out_word <= '{ST_EXISTS, 3'd0, 4'd0, 5'd0, 6'd0, 1'b0};
              out_strobe <= 1'b1; st_r <= S_IDLE;
            end else begin
              ci_r <= '0; st_r <= S_CREQ;
            end
          end else if (!found_r) begin
            out_word <= '{ST_NOTFOUND, 3'd0, 4'd0, 5'd0, 6'd0, 1'b0};
            out_strobe <= 1'b1; st_r <= S_IDLE;
          end else st_r <= S_REL;
        end
        S_CREQ: if (ci_r < CW'(q_cmd.ncand)) st_r <= S_CWAIT;
                else if (share_mode) begin ci_r <= '0; st_r <= S_SREQ; end
                else st_r <= S_PICK;
        S_CWAIT: st_r <= S_CCHK;
        S_CCHK: begin
          if (cand_rdata.width != 6'd0 && cand_rdata.width <= freecols && winfree) begin
            have_r <= 1'b1; sel_r <= cand_rdata; st_r <= S_PICK;
          end else begin
            ci_r <= ci_r + 1'b1; st_r <= S_CREQ;
          end
        end
        S_SREQ: if (ci_r < CW'(q_cmd.ncand)) st_r <= S_SWAIT;
                else st_r <= S_PICK;
        S_SWAIT: begin pi_r <= '0; st_r <= S_SPART; end
        S_SPART: begin
          if (pi_r < (PW+1)'(MAX_PARTS)) begin
            if (cand_rdata.width != 6'd0 && pv_r[pi_r[PW-1:0]] &&
                pfc_r[pi_r[PW-1:0]] == cand_rdata.start &&
                pcc_r[pi_r[PW-1:0]] == cand_rdata.width &&
                (!part_ok_r || psc_r[part_r] > psc_r[pi_r[PW-1:0]])) begin
              part_ok_r <= 1'b1; part_r <= pi_r[PW-1:0];
              have_r <= 1'b1; sel_r <= cand_rdata;
            end
            pi_r <= pi_r + 1'b1;
          end else begin
            ci_r <= ci_r + 1'b1; st_r <= S_SREQ;
          end
        end
        S_PICK: begin
          if (!have_r) begin
            out_word <= '{ST_BUSY, 3'd0, 4'd0, 5'd0, 6'd0, 1'b0};
            out_strobe <= 1'b1; st_r <= S_IDLE;
          end else begin
            found_r <= 1'b0;
            for (int i = MAX_REQUESTS - 1; i >= 0; i--)
              if (!rv_r[i]) begin found_r <= 1'b1; rs_r <= RW'(i); end
            st_r <= S_PSLOT;
          end
        end
        S_PSLOT: begin
          st_r <= S_COMMIT;
          if (!part_ok_r) begin
            have_r <= 1'b0;
            for (int i = MAX_PARTS - 1; i >= 0; i--)
              if (!pv_r[i]) begin have_r <= 1'b1; part_r <= PW'(i); end
          end
        end
        S_COMMIT: begin
          st_r <= S_IDLE; out_strobe <= 1'b1;
          if (!found_r || (!part_ok_r && !have_r))
            out_word <= '{ST_FULL, 3'd0, 4'd0, 5'd0, 6'd0, 1'b0};
          else begin
            if (!part_ok_r) begin
              pv_r[part_r] <= 1'b1; pfc_r[part_r] <= sel_r.start;
              pcc_r[part_r] <= sel_r.width; psc_r[part_r] <= 5'd1;
              busy_r <= busy_r | ((32'd1 << sel_r.width[4:0]) -
                        32'(sel_r.width != 6'd32) << sel_r.start) |
                        (sel_r.width[5] ? 32'hFFFF_FFFF << sel_r.start : 32'd0);
              inuse_r <= inuse_r + sel_r.width;
            end else if (psc_r[part_r] < 5'd31)
              psc_r[part_r] <= psc_r[part_r] + 1'b1;
            rv_r[rs_r] <= 1'b1; rid_r[rs_r] <= q_cmd.request_id;
            rps_r[rs_r] <= part_r;
            out_word <= '{ST_OK, sel_r.layout, sel_r.option, sel_r.start,
                          sel_r.width, !part_ok_r};
          end
        end
        S_REL: begin
          st_r <= S_IDLE; out_strobe <= 1'b1;
          if (!pv_r[rps_r[hit_r]])
            out_word <= '{ST_BAD, 3'd0, 4'd0, 5'd0, 6'd0, 1'b0};
          else begin
            out_word <= '{ST_OK, 3'd0, 4'd0, 5'd0, 6'd0, 1'b0};
            rv_r[hit_r] <= 1'b0;
            if (psc_r[rps_r[hit_r]] > 5'd1)
              psc_r[rps_r[hit_r]] <= psc_r[rps_r[hit_r]] - 1'b1;
            else begin
              psc_r[rps_r[hit_r]] <= 5'd0;
              pv_r[rps_r[hit_r]] <= 1'b0;
              busy_r <= busy_r & ~(32'((((64'd1 << pcc_r[rps_r[hit_r]]) - 64'd1)
                        << pfc_r[rps_r[hit_r]])));
              inuse_r <= (inuse_r >= pcc_r[rps_r[hit_r]]) ?
                         inuse_r - pcc_r[rps_r[hit_r]] : 6'd0;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/column_partition_allocator.sv
// Top level of the column partition allocator.
// Only one command is in flight; busy drops in the result cycle. Request, candidate
// and partition scans in the back end set the rate. The receiver cannot stall.
// Synchronous active-low reset clears all valid bits, the candidate count, the busy
// columns and the in-use count, and sets the config to 32 columns with sharing off.
module column_partition_allocator import cpa_pkg::*; #(
  parameter int MAX_PARTS    = MAX_PARTS_D,
  parameter int MAX_REQUESTS = MAX_REQUESTS_D,
  parameter int MAX_CANDS    = MAX_CANDS_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [5:0] cfg_data
);
  logic [5:0] total_r;
  logic       share_r;
  cmd_t       q_cmd;
  logic       q_valid, q_pop;
  logic [$clog2(MAX_CANDS)-1:0] raddr;
  cand_t      rdata;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 6'd32; share_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TOTAL) total_r <= cfg_data;
      else share_r <= cfg_data[0];
    end
  end

  cpa_front #(.MAX_CANDS(MAX_CANDS)) u_front (
    .clk, .rst_n, .start, .busy, .in_word, .q_cmd, .q_valid, .q_pop,
    .cand_raddr(raddr), .cand_rdata(rdata));

  cpa_back #(.MAX_PARTS(MAX_PARTS), .MAX_REQUESTS(MAX_REQUESTS),
             .MAX_CANDS(MAX_CANDS)) u_back (
    .clk, .rst_n, .total_columns(total_r), .share_mode(share_r),
    .q_cmd, .q_valid, .q_pop, .cand_raddr(raddr), .cand_rdata(rdata),
    .out_strobe, .out_word);
endmodule

>>> design/cpa_checker.sv
// Port-level checker for the column partition allocator.
module cpa_checker import cpa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_word_t out_word
);
  a_no_strobe_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("double strobe");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_word.status <= ST_BAD) else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.status != ST_OK |-> out_word.granted_width == 6'd0)
    else $error("nonzero fields");
  // busy only rises after a word was taken
  a_busy_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without start");
endmodule

bind column_partition_allocator cpa_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_word);

>>> bench/tb_column_partition_allocator.sv
// Self-checking testbench for the column partition allocator.
`timescale 1ns / 100ps

module tb_column_partition_allocator;
  import cpa_pkg::*;

  localparam int NPARTS = 16;
  localparam int NREQS  = 16;
  localparam int NCANDS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [5:0] cfg_data;

  column_partition_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Shadow copy of the allocator state, kept in step with accepted words.
  logic [5:0]  sh_total;
  logic        sh_share;
  logic [31:0] sh_busy_cols;
  int unsigned sh_in_use;
  logic        sh_pvalid [NPARTS];
  logic [4:0]  sh_pfirst [NPARTS];
  logic [5:0]  sh_pcount [NPARTS];
  logic [4:0]  sh_pshare [NPARTS];
  logic        sh_rvalid [NREQS];
  logic [31:0] sh_rident [NREQS];
  logic [3:0]  sh_rslot  [NREQS];
  cand_t       sh_cands  [NCANDS];
  int unsigned sh_ncand;

  out_word_t expected_words[$];
  int  mismatches;
  bit  failed;
  int  idle_cycles;
  int  sender_idle_pct;
  logic [31:0] recent_ids[$];

  function automatic int unsigned eff_total();
    return (sh_total > 32) ? 32 : sh_total;
  endfunction

  function automatic bit window_free(int unsigned s, int unsigned w);
    for (int unsigned k = 0; k < w; k++) begin
      if (s + k >= eff_total()) return 1'b0;
      if (sh_busy_cols[s + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void mark_cols(int unsigned s, int unsigned w, bit v);
    for (int unsigned k = 0; k < w; k++)
      if (s + k < 32) sh_busy_cols[s + k] = v;
  endfunction

  function automatic out_word_t status_only(logic [2:0] st);
    out_word_t o;
    o = '0;
    o.status = st;
    return o;
  endfunction

  function automatic out_word_t predict_allocate(logic [31:0] id);
    int unsigned lim, freecols, w, s;
    int cand, part, rs, ps;
    out_word_t o;
    cand = -1; part = -1; rs = -1; ps = -1;
    lim = eff_total();
    freecols = (lim > sh_in_use) ? lim - sh_in_use : 0;
    for (int r = 0; r < NREQS; r++)
      if (sh_rvalid[r] && sh_rident[r] == id) return status_only(ST_EXISTS);
    for (int c = 0; c < sh_ncand; c++) begin
      w = sh_cands[c].width;
      if (w == 0 || w > freecols) continue;
      if (window_free(sh_cands[c].start, w)) begin
        cand = c;
        break;
      end
    end
    if (cand < 0 && sh_share) begin
      for (int c = 0; c < sh_ncand; c++) begin
        w = sh_cands[c].width;
        s = sh_cands[c].start;
        if (w == 0) continue;
        for (int p = 0; p < NPARTS; p++) begin
          if (!sh_pvalid[p] || sh_pfirst[p] != s || sh_pcount[p] != w) continue;
          if (part >= 0 && sh_pshare[part] <= sh_pshare[p]) continue;
          part = p;
          cand = c;
        end
      end
    end
    if (cand < 0) return status_only(ST_BUSY);
    for (int r = 0; r < NREQS; r++)
      if (!sh_rvalid[r]) begin
        rs = r;
        break;
      end
    if (rs < 0) return status_only(ST_FULL);
    w = sh_cands[cand].width;
    s = sh_cands[cand].start;
    if (part < 0) begin
      for (int p = 0; p < NPARTS; p++)
        if (!sh_pvalid[p]) begin
          ps = p;
          break;
        end
      if (ps < 0) return status_only(ST_FULL);
      part = ps;
      sh_pvalid[part] = 1'b1;
      sh_pfirst[part] = 5'(s);
      sh_pcount[part] = 6'(w);
      sh_pshare[part] = 5'd1;
      mark_cols(s, w, 1'b1);
      sh_in_use += w;
    end else if (sh_pshare[part] < 31) begin
      sh_pshare[part]++;
    end
    sh_rvalid[rs] = 1'b1;
    sh_rident[rs] = id;
    sh_rslot[rs]  = 4'(part);
    o = '0;
    o.status        = ST_OK;
    o.chosen_layout = sh_cands[cand].layout;
    o.chosen_option = sh_cands[cand].option;
    o.granted_start = 5'(s);
    o.granted_width = 6'(w);
    o.load_needed   = (ps >= 0);
    return o;
  endfunction

  function automatic out_word_t predict_release(logic [31:0] id);
    int r;
    int unsigned p;
    r = -1;
    for (int i = 0; i < NREQS; i++)
      if (sh_rvalid[i] && sh_rident[i] == id) begin
        r = i;
        break;
      end
    if (r < 0) return status_only(ST_NOTFOUND);
    p = sh_rslot[r];
    if (!sh_pvalid[p]) return status_only(ST_BAD);
    if (sh_pshare[p] > 0) sh_pshare[p]--;
    if (sh_pshare[p] == 0) begin
      sh_pvalid[p] = 1'b0;
      mark_cols(sh_pfirst[p], sh_pcount[p], 1'b0);
      sh_in_use = (sh_in_use >= sh_pcount[p]) ? sh_in_use - sh_pcount[p] : 0;
    end
    sh_rvalid[r] = 1'b0;
    return status_only(ST_OK);
  endfunction

  // Update the shadow state for one accepted word and queue its result.
  function automatic void predict_word(in_word_t w);
    cand_t c;
    case (w.func)
      FN_CAND: begin
        if (sh_ncand < NCANDS) begin
          c.layout = w.cand_layout;
          c.option = w.cand_option;
          c.width  = w.cand_width;
          c.start  = w.cand_start;
          sh_cands[sh_ncand] = c;
          sh_ncand++;
        end
      end
      FN_ALLOC: begin
        expected_words.push_back(predict_allocate(w.request_id));
        sh_ncand = 0;
      end
      FN_RELEASE: expected_words.push_back(predict_release(w.request_id));
      default: ;
    endcase
  endfunction

  // Result checker: receiver cannot stall, so every strobe is a result.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word !== exp_w) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d lay=%0d opt=%0d s=%0d w=%0d ld=%0b,",
                      " got st=%0d lay=%0d opt=%0d s=%0d w=%0d ld=%0b"},
                     exp_w.status, exp_w.chosen_layout, exp_w.chosen_option,
                     exp_w.granted_start, exp_w.granted_width, exp_w.load_needed,
                     out_word.status, out_word.chosen_layout, out_word.chosen_option,
                     out_word.granted_start, out_word.granted_width,
                     out_word.load_needed);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word, result or register write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one word; start stays high until the edge that accepts it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    start   = 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predict_word(w);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_cand(int lay, int opt, int wid, int st);
    in_word_t w;
    w = in_word_t'({$urandom(), $urandom()});
    w.func = FN_CAND;
    w.cand_layout = 3'(lay);
    w.cand_option = 4'(opt);
    w.cand_width  = 6'(wid);
    w.cand_start  = 5'(st);
    send_word(w);
  endtask

  task automatic send_req(logic [1:0] fn, logic [31:0] id);
    in_word_t w;
    w = in_word_t'({$urandom(), $urandom()});
    w.func = fn;
    w.request_id = id;
    send_word(w);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_reg(logic idx, logic [5:0] val);
    cfg_valid = 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TOTAL) sh_total = val;
    else sh_share = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    write_reg(CFG_SHARE, 6'd1);
    send_req(FN_ALLOC, 32'h0);            // no candidates
    send_cand(0, 0, 32, 0);               // full row
    send_req(FN_ALLOC, 32'h0);
    send_cand(7, 15, 32, 31);             // runs past the total
    send_cand(1, 3, 0, 4);                // zero width
    send_cand(0, 0, 32, 0);
    send_req(FN_ALLOC, 32'hFFFF_FFFF);    // shares the full row
    send_req(FN_ALLOC, 32'hFFFF_FFFF);    // id exists
    send_req(FN_RELEASE, 32'h1234_5678);  // not found
    send_req(FN_RELEASE, 32'h0);
    send_req(FN_RELEASE, 32'hFFFF_FFFF);
    send_req(FN_UNUSED, 32'h5);           // ignored func
    for (int i = 0; i < 18; i++) send_cand(i / 3, i % 16, 1, i);  // overflow
    send_req(FN_ALLOC, 32'h42);
    send_req(FN_RELEASE, 32'h42);
    wait_drained();
    write_reg(CFG_TOTAL, 6'd1);
    send_cand(2, 5, 1, 0);
    send_cand(3, 6, 2, 0);
    send_req(FN_ALLOC, 32'h7);
    wait_drained();
    write_reg(CFG_TOTAL, 6'd0);           // lowered while in use
    send_cand(2, 5, 1, 0);
    send_req(FN_ALLOC, 32'h8);
    send_req(FN_RELEASE, 32'h7);
    send_req(FN_RELEASE, 32'h8);
    wait_drained();
    write_reg(CFG_TOTAL, 6'd63);
  endtask

  function automatic logic [31:0] pick_id();
    if (recent_ids.size() != 0 && $urandom_range(2) != 0)
      return recent_ids[$urandom_range(recent_ids.size() - 1)];
    return $urandom_range(15) == 0 ? $urandom() : $urandom_range(40);
  endfunction

  // Mostly well-formed candidate lists plus allocates, releases and unused-function words.
  task automatic test_random(int n_words);
    int sent, ncand, lay, wid;
    logic [31:0] id;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          ncand = $urandom_range(4);
          lay = 0;
          for (int i = 0; i < ncand; i++) begin
            lay = lay + $urandom_range(1);
            if (lay > 7) lay = 7;
            wid = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 8);
            send_cand(lay, $urandom_range(15), wid,
                      ($urandom_range(3) == 0) ? $urandom_range(31) : 4 * $urandom_range(7));
          end
          id = pick_id();
          recent_ids.push_back(id);
          if (recent_ids.size() > 24) void'(recent_ids.pop_front());
          send_req(FN_ALLOC, id);
          sent += ncand + 1;
        end
        6, 7, 8: begin
          send_req(FN_RELEASE, pick_id());
          sent++;
        end
        default: begin
          send_req(FN_UNUSED, $urandom());
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_config_phases();
    sender_idle_pct = 26;
    write_reg(CFG_TOTAL, 6'd32);
    write_reg(CFG_SHARE, 6'd0);
    test_random(130);
    wait_drained();                       // sender holds off until drained
    sender_idle_pct = 58;
    write_reg(CFG_TOTAL, 6'd12);
    write_reg(CFG_SHARE, 6'd1);
    test_random(130);
    wait_drained();
    sender_idle_pct = 0;
    write_reg(CFG_TOTAL, 6'd32);
    test_random(140);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TOTAL;
    cfg_data = '0;
    mismatches = 0;
    failed = 1'b0;
    idle_cycles = 0;
    sender_idle_pct = 0;
    sh_total = 6'd32;
    sh_share = 1'b0;
    sh_busy_cols = '0;
    sh_in_use = 0;
    sh_ncand = 0;
    for (int i = 0; i < NPARTS; i++) sh_pvalid[i] = 1'b0;
    for (int i = 0; i < NREQS; i++) sh_rvalid[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_phases();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed && expected_words.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
